### rtl/cbs_pkg.sv
// Shared types, constants and arithmetic helpers for the cubic Bezier sampler.
// Used by cbs_front, cbs_sampler, cbs_eval and the top level. No dependencies.
`default_nettype none

package cbs_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_SAMPLES = 64;
  localparam int COORD_W     = 32;
  localparam int NUM_CTRL    = 12;
  localparam int NUM_AXES    = 3;
  localparam int STEP_W      = 17;
  localparam int T_W         = FRAC_BITS + 1;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = DIFF_W + T_W + 1;
  localparam int CNT_W       = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(4096);
  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) << (FRAC_BITS - 1);

  typedef logic [COORD_W-1:0] coord_t;
  // Element i holds field i: start_x, start_y, start_z, pull1_x, ... finish_z.
  typedef coord_t [NUM_CTRL-1:0] seg_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // One sample issued by the sequencer into the evaluation pipeline.
  typedef struct packed {
    logic           vld;
    logic           last;
    logic [T_W-1:0] t;
  } smp_t;

  // Rescale a Q1.16 step to FRAC_BITS fraction bits, truncating when narrower.
  function automatic logic [T_W-1:0] scale_step(input logic [STEP_W-1:0] s);
    logic [STEP_W+FRAC_BITS-1:0] wide;
    wide = (STEP_W + FRAC_BITS)'(s) << FRAC_BITS;
    return T_W'(wide >> 16);
  endfunction

  // First half of a linear interpolation: (b - a) * u at full precision.
  function automatic prod_t lerp_mul(input coord_t a, input coord_t b,
                                     input logic [T_W-1:0] u);
    logic signed [DIFF_W-1:0] d;
    logic signed [T_W:0]      us;
    prod_t                    pr;
    d  = $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
    us = $signed({1'b0, u});
    pr = d * us;
    return pr;
  endfunction

  // Second half: round half up, floor shift, add the base. The result always
  // lies between the two operands, so the 32-bit wrap is exact.
  function automatic coord_t lerp_add(input coord_t a, input prod_t p);
    prod_t r;
    r = (p + HALF_P) >>> FRAC_BITS;
    return a + r[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/cbs_front.sv
// Input side of the sampler: takes segment transactions into a short queue.
// Depends on cbs_pkg.
`default_nettype none

module cbs_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire cbs_pkg::seg_t  in_seg,
  output logic                q_valid,
  output cbs_pkg::seg_t       q_seg,
  input  wire logic           q_pop
);

  cbs_pkg::seg_t mem_r [cbs_pkg::FIFO_DEPTH];
  logic [cbs_pkg::PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [cbs_pkg::PTR_W:0]   cnt_r, cnt_nxt;
  logic push;
  logic pop;

  assign in_ready = (cnt_r != (cbs_pkg::PTR_W + 1)'(cbs_pkg::FIFO_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_seg    = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_seg;
    end
  end

endmodule

`default_nettype wire

### rtl/cbs_sampler.sv
// Sequencer: holds the current segment and issues one parameter value t per
// cycle while the pipeline advances, marking the last sample. Depends on cbs_pkg.
`default_nettype none

module cbs_sampler (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic [cbs_pkg::STEP_W-1:0]   step,
  input  wire logic                         q_valid,
  input  wire cbs_pkg::seg_t                q_seg,
  output logic                              q_pop,
  input  wire logic                         advance,
  output cbs_pkg::seg_t                     pts,
  output cbs_pkg::smp_t                     smp
);

  localparam logic [cbs_pkg::T_W:0] ONE_T = (cbs_pkg::T_W + 1)'(1) << cbs_pkg::FRAC_BITS;

  cbs_pkg::seg_t pts_r;
  logic                          busy_r;
  logic [cbs_pkg::T_W-1:0]       t_r;
  logic [cbs_pkg::CNT_W-1:0]     cnt_r;
  logic [cbs_pkg::T_W-1:0]       dt;
  logic [cbs_pkg::T_W:0]         t_nxt;
  logic                          last;

  assign dt    = cbs_pkg::scale_step(step);
  assign t_nxt = {1'b0, t_r} + {1'b0, dt};
  assign last  = (t_nxt > ONE_T) ||
                 (cnt_r == cbs_pkg::CNT_W'(cbs_pkg::MAX_SAMPLES - 1));
  assign q_pop = !busy_r;
  assign pts   = pts_r;

  always_comb begin
    smp.vld  = busy_r;
    smp.last = last;
    smp.t    = t_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      t_r    <= '0;
      cnt_r  <= '0;
    end else if (!busy_r) begin
      if (q_valid) begin
        busy_r <= 1'b1;
        t_r    <= '0;
        cnt_r  <= '0;
      end
    end else if (advance) begin
      // The stored t never exceeds one, so it fits in T_W bits.
      t_r   <= t_nxt[cbs_pkg::T_W-1:0];
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
        t_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && q_valid) begin
      pts_r <= q_seg;
    end
  end

endmodule

`default_nettype wire

### rtl/cbs_eval.sv
// Evaluation pipeline: three levels of de Casteljau interpolation per axis,
// each a multiply stage and a round-and-add stage, ending in the output
// register. Depends on cbs_pkg.
`default_nettype none

module cbs_eval (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cbs_pkg::seg_t        pts,
  input  wire cbs_pkg::smp_t        smp,
  output logic                      advance,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [3*cbs_pkg::COORD_W-1:0] out_point,
  output logic                      out_last
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  logic l1_r, l2_r, l3_r, l4_r, l5_r, lo_r;
  logic [cbs_pkg::T_W-1:0] t1_r, t2_r, t3_r, t4_r;

  // The whole pipeline moves together unless the output register is held.
  assign advance   = !vo_r || out_ready;
  assign out_valid = vo_r;
  assign out_last  = lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (advance) begin
      v1_r <= smp.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      vo_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      l1_r <= smp.last;
      l2_r <= l1_r;
      l3_r <= l2_r;
      l4_r <= l3_r;
      l5_r <= l4_r;
      lo_r <= l5_r;
      t1_r <= smp.t;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
    end
  end

  for (genvar ax = 0; ax < cbs_pkg::NUM_AXES; ax++) begin : g_axis
    cbs_pkg::coord_t p0, p1, p2, p3;
    cbs_pkg::prod_t  m_ab_r, m_bc_r, m_cd_r, m_de_r, m_ef_r, m_g_r;
    cbs_pkg::coord_t b0_r, b1_r, b2_r;
    cbs_pkg::coord_t a_r, b_r, c_r;
    cbs_pkg::coord_t ba_r, bb_r;
    cbs_pkg::coord_t d_r, e_r;
    cbs_pkg::coord_t bd_r;
    cbs_pkg::coord_t res_r;

    assign p0 = pts[ax];
    assign p1 = pts[cbs_pkg::NUM_AXES + ax];
    assign p2 = pts[2*cbs_pkg::NUM_AXES + ax];
    assign p3 = pts[3*cbs_pkg::NUM_AXES + ax];

    always_ff @(posedge clk) begin
      if (advance) begin
        // Level one: the three control polygon edges.
        m_ab_r <= cbs_pkg::lerp_mul(p0, p1, smp.t);
        m_bc_r <= cbs_pkg::lerp_mul(p1, p2, smp.t);
        m_cd_r <= cbs_pkg::lerp_mul(p2, p3, smp.t);
        b0_r   <= p0;
        b1_r   <= p1;
        b2_r   <= p2;
        a_r    <= cbs_pkg::lerp_add(b0_r, m_ab_r);
        b_r    <= cbs_pkg::lerp_add(b1_r, m_bc_r);
        c_r    <= cbs_pkg::lerp_add(b2_r, m_cd_r);
        // Level two.
        m_de_r <= cbs_pkg::lerp_mul(a_r, b_r, t2_r);
        m_ef_r <= cbs_pkg::lerp_mul(b_r, c_r, t2_r);
        ba_r   <= a_r;
        bb_r   <= b_r;
        d_r    <= cbs_pkg::lerp_add(ba_r, m_de_r);
        e_r    <= cbs_pkg::lerp_add(bb_r, m_ef_r);
        // Level three.
        m_g_r  <= cbs_pkg::lerp_mul(d_r, e_r, t4_r);
        bd_r   <= d_r;
        res_r  <= cbs_pkg::lerp_add(bd_r, m_g_r);
      end
    end

    assign out_point[ax*cbs_pkg::COORD_W +: cbs_pkg::COORD_W] = res_r;
  end

endmodule

`default_nettype wire

### rtl/cubic_bezier_curve_sampler_top.sv
// Top level of the cubic Bezier sampler: step register, input queue,
// sequencer and evaluation pipeline. Depends on cbs_pkg and all cbs_ modules.
`default_nettype none

// Each input transaction carries the four control points of one cubic Bezier
// segment in signed Q16.16. The block emits min(64, floor(65536 / dt) + 1)
// points at t = 0, dt, 2dt, ... with t <= 1, one point per cycle unless
// out_tready stalls the output, the last one flagged on out_tlast. The
// sequencer issues one t per cycle while the pipeline advances, and between
// segments it goes idle to load the next one from the two-entry input queue,
// issuing no t while it loads; each point passes a pipeline of three multiply
// and round-and-add levels. Up to two further segments are accepted while one
// is being sampled. The step dt (Q1.16, reset 4096) is written through
// cfg_wr_en and must only change while the block is idle.
module cubic_bezier_curve_sampler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [16:0] cfg_wr_data,  // step_size
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // From bit 0 up: start_x, start_y, start_z, pull1_x, pull1_y, pull1_z,
  // pull2_x, pull2_y, pull2_z, finish_x, finish_y, finish_z.
  input  wire logic [383:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,    // From bit 0 up: point_x, point_y, point_z.
  output logic             out_tlast     // last_sample
);

  logic [cbs_pkg::STEP_W-1:0] step_r;
  logic                       q_valid;
  cbs_pkg::seg_t              q_seg;
  logic                       q_pop;
  cbs_pkg::seg_t              pts;
  cbs_pkg::smp_t              smp;
  logic                       advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cbs_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      step_r <= cfg_wr_data;
    end
  end

  cbs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_seg   (in_tdata),
    .q_valid  (q_valid),
    .q_seg    (q_seg),
    .q_pop    (q_pop)
  );

  cbs_sampler u_sampler (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step_r),
    .q_valid (q_valid),
    .q_seg   (q_seg),
    .q_pop   (q_pop),
    .advance (advance),
    .pts     (pts),
    .smp     (smp)
  );

  cbs_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .pts       (pts),
    .smp       (smp),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_point (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire
